// ===== rtl/core/vn_pkg.sv =====
// Shared constants and stage types of the vector normalization pipeline.
// No dependencies.
`timescale 1ns / 1ps

package vn_pkg;

   localparam int COMP_BITS = 32;
   localparam int FRAC_BITS = 30;
   localparam int FIELD_BITS = 32;
   localparam int LANES = 3;
   localparam int CELLS = FRAC_BITS + 1;
   localparam int SQ_BITS = 2 * COMP_BITS;
   localparam int WIDE_BITS = 2 * COMP_BITS + 2 * FRAC_BITS + 2;
   localparam int Q_BITS = FRAC_BITS + 1;

   typedef struct packed {
      logic                 neg;
      logic [WIDE_BITS-1:0] rem;
      logic [WIDE_BITS-1:0] acc;
      logic [Q_BITS-1:0]    q;
   } vn_lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic [WIDE_BITS-1:0] step;
      vn_lane_type [LANES-1:0] lane;
   } vn_stage_type;

endpackage

// ===== rtl/core/vn_req_if.sv =====
// Request channel of the vector normalizer: valid, ready and three components.
// Depends on vn_pkg.
`timescale 1ns / 1ps

interface vn_req_if;
   logic valid;
   logic ready;
   logic signed [vn_pkg::FIELD_BITS-1:0] comp_x;
   logic signed [vn_pkg::FIELD_BITS-1:0] comp_y;
   logic signed [vn_pkg::FIELD_BITS-1:0] comp_z;

   modport source (output valid, comp_x, comp_y, comp_z, input ready);
   modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

// ===== rtl/core/vn_rsp_if.sv =====
// Response channel of the vector normalizer: valid, ready, unit vector, status.
// Depends on vn_pkg.
`timescale 1ns / 1ps

interface vn_rsp_if;
   logic valid;
   logic ready;
   logic signed [vn_pkg::FIELD_BITS-1:0] unit_x;
   logic signed [vn_pkg::FIELD_BITS-1:0] unit_y;
   logic signed [vn_pkg::FIELD_BITS-1:0] unit_z;
   logic status;

   modport source (output valid, unit_x, unit_y, unit_z, status, input ready);
   modport sink (input valid, unit_x, unit_y, unit_z, status, output ready);
endinterface

// ===== rtl/core/vector3_normalize.sv =====
// Vector normalizer top: front stages, chain of bit cells, response register.
// One request per cycle sustained while no response waits on a deasserted ready.
// Reset clears all stage valid bits; the whole pipeline stalls while a response waits.
// Depends on vn_pkg, vn_req_if, vn_rsp_if, vn_front and vn_cell.
`timescale 1ns / 1ps

module vector3_normalize (
   input  logic clock,
   input  logic reset,
   vn_req_if.sink req_ch,
   vn_rsp_if.source rsp_ch
);
   logic en;
   vn_pkg::vn_stage_type chain [vn_pkg::CELLS+1];
   logic [vn_pkg::LANES-1:0][vn_pkg::FIELD_BITS-1:0] comp;
   logic [vn_pkg::LANES-1:0][vn_pkg::FIELD_BITS-1:0] unit_ff, unit_in;
   logic valid_ff, status_ff;
   vn_pkg::vn_stage_type last;

   assign en = !valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign comp = {req_ch.comp_z, req_ch.comp_y, req_ch.comp_x};

   vn_front front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_ch.valid),
      .comp(comp), .seed(chain[0])
   );

   for (genvar g = 0; g < vn_pkg::CELLS; g++) begin : g_cell
      vn_cell cell_i (
         .clock(clock), .reset(reset), .en(en), .din(chain[g]), .dout(chain[g+1])
      );
   end

   assign last = chain[vn_pkg::CELLS];

   always_comb begin
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         if (last.zero) begin
            unit_in[i] = '0;
         end else if (last.lane[i].neg) begin
            unit_in[i] = -vn_pkg::FIELD_BITS'(last.lane[i].q);
         end else begin
            unit_in[i] = vn_pkg::FIELD_BITS'(last.lane[i].q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
         status_ff <= last.zero;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= last.valid;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.unit_x = unit_ff[0];
   assign rsp_ch.unit_y = unit_ff[1];
   assign rsp_ch.unit_z = unit_ff[2];
   assign rsp_ch.status = status_ff;

`ifndef SYNTHESIS
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status |->
         rsp_ch.unit_x == 0 && rsp_ch.unit_y == 0 && rsp_ch.unit_z == 0)
      else $error("zero vector response carries nonzero components");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         $signed(rsp_ch.unit_x) <= $signed(32'sd1 <<< vn_pkg::FRAC_BITS) &&
         $signed(rsp_ch.unit_x) >= -$signed(32'sd1 <<< vn_pkg::FRAC_BITS))
      else $error("unit component out of range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.unit_y))
      else $error("stalled response lost");
`endif
endmodule

// ===== rtl/core/vn_front.sv =====
// Front stages: component magnitudes, squares, squared length and cell seed.
// Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_front (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [vn_pkg::LANES-1:0][vn_pkg::FIELD_BITS-1:0] comp,
   output vn_pkg::vn_stage_type seed
);
   logic [vn_pkg::LANES-1:0][vn_pkg::COMP_BITS-1:0] mag_ff;
   logic [vn_pkg::LANES-1:0] neg0_ff, neg1_ff;
   logic [vn_pkg::LANES-1:0][vn_pkg::SQ_BITS-1:0] sq_ff;
   logic v0_ff, v1_ff;
   vn_pkg::vn_stage_type seed_ff, seed_in;
   logic [vn_pkg::SQ_BITS-1:0] sum;

   always_comb begin
      sum = sq_ff[0] + sq_ff[1] + sq_ff[2];
      seed_in.valid = v1_ff;
      seed_in.zero = (sum == '0);
      seed_in.step = vn_pkg::WIDE_BITS'(sum) << (2 * vn_pkg::FRAC_BITS);
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         seed_in.lane[i].neg = neg1_ff[i];
         seed_in.lane[i].rem = vn_pkg::WIDE_BITS'(sq_ff[i]) << (2 * vn_pkg::FRAC_BITS);
         seed_in.lane[i].acc = '0;
         seed_in.lane[i].q = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < vn_pkg::LANES; i++) begin
            neg0_ff[i] <= comp[i][vn_pkg::COMP_BITS-1];
            mag_ff[i] <= comp[i][vn_pkg::COMP_BITS-1] ?
                         vn_pkg::COMP_BITS'(-comp[i][vn_pkg::COMP_BITS-1:0]) :
                         comp[i][vn_pkg::COMP_BITS-1:0];
            sq_ff[i] <= vn_pkg::SQ_BITS'(mag_ff[i]) * vn_pkg::SQ_BITS'(mag_ff[i]);
         end
         neg1_ff <= neg0_ff;
      end
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         seed_ff.valid <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         seed_ff <= seed_in;
      end
   end

   assign seed = seed_ff;
endmodule

// ===== rtl/core/vn_cell.sv =====
// One cell of the chain: decides one quotient bit for each lane.
// Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  vn_pkg::vn_stage_type din,
   output vn_pkg::vn_stage_type dout
);
   vn_pkg::vn_stage_type out_ff, out_in;
   logic [vn_pkg::WIDE_BITS-1:0] trial;
   logic [vn_pkg::WIDE_BITS-1:0] acc_next;
   logic take;

   always_comb begin
      out_in = din;
      out_in.step = din.step >> 2;
      trial = '0;
      acc_next = '0;
      take = 1'b0;
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         trial = din.lane[i].acc + din.step;
         take = (din.lane[i].rem >= trial);
         acc_next = take ? (din.lane[i].acc + (din.step << 1)) : din.lane[i].acc;
         out_in.lane[i].rem = take ? (din.lane[i].rem - trial) : din.lane[i].rem;
         out_in.lane[i].acc = acc_next >> 1;
         out_in.lane[i].q = {din.lane[i].q[vn_pkg::Q_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;
endmodule

// ===== tb/vn_tb_if.sv =====
// Testbench copies of the request and response channel interfaces are not needed;
// this file holds the scoreboard class. Depends on vn_pkg.
`timescale 1ns / 1ps

class vn_unit_scoreboard;
   logic signed [31:0] want_x[$], want_y[$], want_z[$];
   logic               want_status[$];
   int                 errors = 0;

   function automatic logic [63:0] comp_mag(logic [31:0] raw);
      logic [63:0] v;
      v = {32'b0, raw};
      if (raw[31]) v = {32'b0, (~raw) + 32'd1};
      return v;
   endfunction

   function automatic logic [31:0] unit_mag(logic [63:0] m, logic [63:0] s);
      logic [127:0] target, prod;
      logic [63:0]  q, cand;
      target = {64'b0, m * m} << (2 * vn_pkg::FRAC_BITS);
      q = 0;
      for (int b = vn_pkg::FRAC_BITS; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         prod = {64'b0, cand * cand} * {64'b0, s};
         if (prod <= target) q = cand;
      end
      return q[31:0];
   endfunction

   function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [63:0] mx, my, mz, s;
      logic [31:0] ux, uy, uz;
      mx = comp_mag(x);
      my = comp_mag(y);
      mz = comp_mag(z);
      s = mx * mx + my * my + mz * mz;
      if (s == 0) begin
         want_x.push_back(0); want_y.push_back(0); want_z.push_back(0);
         want_status.push_back(1'b1);
      end else begin
         ux = unit_mag(mx, s);
         uy = unit_mag(my, s);
         uz = unit_mag(mz, s);
         want_x.push_back(x[31] ? -ux : ux);
         want_y.push_back(y[31] ? -uy : uy);
         want_z.push_back(z[31] ? -uz : uz);
         want_status.push_back(1'b0);
      end
   endfunction

   function void check_response(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic st);
      logic [31:0] ex, ey, ez;
      logic        es;
      if (want_x.size() == 0) begin
         $error("unexpected response x=%0d y=%0d z=%0d", $signed(x), $signed(y),
                $signed(z));
         errors++;
         return;
      end
      ex = want_x.pop_front();
      ey = want_y.pop_front();
      ez = want_z.pop_front();
      es = want_status.pop_front();
      if (x !== ex) begin
         $error("unit_x expected %0d actual %0d", $signed(ex), $signed(x)); errors++;
      end
      if (y !== ey) begin
         $error("unit_y expected %0d actual %0d", $signed(ey), $signed(y)); errors++;
      end
      if (z !== ez) begin
         $error("unit_z expected %0d actual %0d", $signed(ez), $signed(z)); errors++;
      end
      if (st !== es) begin
         $error("status expected %0d actual %0d", es, st); errors++;
      end
   endfunction

   function int pending();
      return want_x.size();
   endfunction
endclass

// ===== tb/tb_top.sv =====
// Top of the vector normalizer testbench: clock, reset, request driver, response
// sink and watchdog. Depends on vn_pkg, vn_req_if, vn_rsp_if, vn_tb_if.sv and vector3_normalize.
`timescale 1ns / 1ps

module tb_top;
   localparam int LATENCY = vn_pkg::FRAC_BITS + 5;
   localparam int WATCHDOG_LIMIT = 20 * (LATENCY + 40);

   logic clock = 0;
   logic reset = 1;
   vn_req_if req_ch();
   vn_rsp_if rsp_ch();
   vn_unit_scoreboard board = new();
   int  idle_cycles = 0;
   bit  sending_done = 0;

   vector3_normalize dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.comp_x = 0;
      req_ch.comp_y = 0;
      req_ch.comp_z = 0;
      rsp_ch.ready = 0;
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return $urandom_range(0, 15) - 8;
         4: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               int gap);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.comp_x <= x;
      req_ch.comp_y <= y;
      req_ch.comp_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(x, y, z);
   endtask

   initial begin
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 32'h5555_aaaa};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(0, 0, 0, 0);
      send_request(32'h7fff_ffff, 0, 0, 0);
      send_request(0, 32'h8000_0000, 0, 0);
      send_request(0, 0, 32'h8000_0000, 0);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_request(32'h8000_0000, 32'h7fff_ffff, 0, 1);
      send_request(1, 0, 0, 0);
      send_request(0, 32'hffff_ffff, 0, 0);
      send_request(3, 4, 0, 0);
      send_request(1, 1, 1, 0);
      send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
      send_request(32'haaaa_5555, 32'h5555_aaaa, 32'h0f0f_f0f0, 2);
      for (int i = 0; i < 6; i++)
         send_request(edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 4) % 6], 0);
      for (int i = 0; i < 1650; i++) begin
         if (i == 800) begin
            req_ch.valid <= 0;
            while (board.pending() != 0) @(posedge clock);
         end
         send_request(rand_comp(), rand_comp(), rand_comp(),
                      (i / 200) % 2 ? 0 : $urandom_range(0, 15));
      end
      req_ch.valid <= 0;
      sending_done = 1;
   end

   initial begin
      @(negedge reset);
      forever begin
         int wait_cycles;
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_response(rsp_ch.unit_x, rsp_ch.unit_y, rsp_ch.unit_z, rsp_ch.status);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (sending_done);
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end
endmodule
